FILE: design/assert_macros.svh
// assertion macros for the block_reverse_k_group design files, used by brkg_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is high
`define BRKG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define BRKG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/brkg_pkg.sv
// shared constants, types and state encoding for the reverse-in-groups block
`timescale 1ns / 1ps

package brkg_pkg;

   localparam int MAX_GROUP = 64;
   localparam int VALUE_W   = 16;
   localparam int CFG_W     = 7;
   // buffer address; fill level stays below MAX_GROUP between items
   localparam int ADDR_W    = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
   // element count, able to hold MAX_GROUP itself
   localparam int CNT_W     = $clog2(MAX_GROUP + 1);

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_DRAIN
   } brkg_state_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [VALUE_W-1:0] data;
   } brkg_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } brkg_rd_type;

   typedef struct packed {
      logic load;
      logic final_flag;
   } brkg_rsp_ctl_type;

endpackage

FILE: design/brkg_buffer.sv
// group buffer: one write port, one read port with registered read data
`timescale 1ns / 1ps

module brkg_buffer (
   input  logic                         clock,
   input  brkg_pkg::brkg_wr_type        wr,
   input  brkg_pkg::brkg_rd_type        rd,
   output logic [brkg_pkg::VALUE_W-1:0] rd_data
);

   logic [brkg_pkg::VALUE_W-1:0] mem [brkg_pkg::MAX_GROUP];
   logic [brkg_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read data held until the next read
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/brkg_ctrl.sv
// fill tracking and drain sequencer for the group buffer
`timescale 1ns / 1ps

`include "assert_macros.svh"

module brkg_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [brkg_pkg::VALUE_W-1:0]  req_value,
   input  logic                          req_is_final,
   output logic                          req_stall,
   input  logic [brkg_pkg::CFG_W-1:0]    group_size,
   input  logic                          out_free,
   output brkg_pkg::brkg_wr_type         wr,
   output brkg_pkg::brkg_rd_type         rd,
   output brkg_pkg::brkg_rsp_ctl_type    rsp_ctl
);

   brkg_pkg::brkg_state_type state_ff, state_in;

   logic [brkg_pkg::ADDR_W-1:0] fill_ff, fill_in;
   logic [brkg_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [brkg_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic                        rev_ff, rev_in;
   logic                        fin_ff, fin_in;
   logic                        pend_ff, pend_in;
   logic                        pend_final_ff, pend_final_in;

   logic                        accept;
   logic                        issue;
   logic [brkg_pkg::CNT_W-1:0]  k_eff;
   logic [brkg_pkg::CNT_W-1:0]  n_new;
   logic                        emit_rev;
   logic                        emit_fwd;

   // effective group size: zero acts as one, clamp to buffer depth
   always_comb begin
      if (group_size == '0) begin
         k_eff = brkg_pkg::CNT_W'(1);
      end else if (32'(group_size) > brkg_pkg::MAX_GROUP) begin
         k_eff = brkg_pkg::CNT_W'(brkg_pkg::MAX_GROUP);
      end else begin
         k_eff = brkg_pkg::CNT_W'(group_size);
      end
   end

   assign n_new    = brkg_pkg::CNT_W'(fill_ff) + brkg_pkg::CNT_W'(1);
   assign emit_rev = (n_new >= k_eff);
   assign emit_fwd = !emit_rev && req_is_final;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         brkg_pkg::ST_IDLE: begin
            if (accept && (emit_rev || emit_fwd)) begin
               state_in = brkg_pkg::ST_DRAIN;
            end
         end
         brkg_pkg::ST_DRAIN: begin
            if (issue && (cnt_ff == brkg_pkg::CNT_W'(1))) begin
               state_in = brkg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = brkg_pkg::ST_IDLE;
         end
      endcase
   end

   // handshake and memory port controls
   always_comb begin
      req_stall = 1'b1;
      accept    = 1'b0;
      issue     = 1'b0;
      case (state_ff)
         brkg_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            accept    = req_valid;
         end
         brkg_pkg::ST_DRAIN: begin
            issue = !pend_ff || out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
      wr.en        = accept;
      wr.addr      = fill_ff;
      wr.data      = req_value;
      rd.en        = issue;
      rd.addr      = addr_ff;
      rsp_ctl.load       = pend_ff && out_free;
      rsp_ctl.final_flag = pend_final_ff;
   end

   // counters and drain bookkeeping
   always_comb begin
      fill_in       = fill_ff;
      cnt_in        = cnt_ff;
      addr_in       = addr_ff;
      rev_in        = rev_ff;
      fin_in        = fin_ff;
      pend_in       = pend_ff;
      pend_final_in = pend_final_ff;
      if (accept) begin
         if (emit_rev || emit_fwd) begin
            fill_in = '0;
            cnt_in  = n_new;
            rev_in  = emit_rev;
            fin_in  = req_is_final;
            addr_in = emit_rev ? fill_ff : '0;
         end else begin
            fill_in = brkg_pkg::ADDR_W'(n_new);
         end
      end
      if (issue) begin
         cnt_in        = cnt_ff - brkg_pkg::CNT_W'(1);
         addr_in       = rev_ff ? (addr_ff - brkg_pkg::ADDR_W'(1))
                                : (addr_ff + brkg_pkg::ADDR_W'(1));
         pend_in       = 1'b1;
         pend_final_in = fin_ff && (cnt_ff == brkg_pkg::CNT_W'(1));
      end else if (rsp_ctl.load) begin
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brkg_pkg::ST_IDLE;
         fill_ff  <= '0;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      rev_ff        <= rev_in;
      fin_ff        <= fin_in;
      pend_final_ff <= pend_final_in;
   end

   `BRKG_ASSERT(a_drain_has_work, clock, reset,
      (state_ff == brkg_pkg::ST_DRAIN) |-> (cnt_ff != '0), "drain with nothing left")
   `BRKG_ASSERT(a_final_empties, clock, reset,
      (accept && req_is_final) |=> (fill_ff == '0), "buffer not empty after final element")
   `BRKG_ASSERT(a_fill_steps, clock, reset,
      (accept && !emit_rev && !emit_fwd) |=>
      (fill_ff == brkg_pkg::ADDR_W'($past(fill_ff) + brkg_pkg::ADDR_W'(1))),
      "fill level did not advance")

endmodule

FILE: design/block_reverse_k_group.sv
// top level of the reverse-in-groups-of-k stream block
`timescale 1ns / 1ps

// block_reverse_k_group takes a stream of 16-bit values, one transfer at a time,
// with req_is_final on the last element of a sequence. elements are stored in a
// 64-entry buffer; once csr_group_size elements are held the group leaves on the
// rsp channel in reverse order, and a final element that finds a short group
// sends the leftovers out in arrival order. rsp_out_final marks the last result
// of a sequence. group size 0 behaves as 1, sizes above 64 as 64; a size lowered
// mid-group makes the next element flush everything held, reversed.
// timing: an element that does not close a group is taken without a stall. an
// element that closes a group of n starts a drain of n reads from the single
// buffer read port, one per cycle while rsp is not stalled, and no element is
// taken during it. the registered rsp stage lets the next element in while the
// last result of a group still waits to go.
// csr_ready is always high; write the group size only while the block is idle.

module block_reverse_k_group (
   input  logic        clock,
   input  logic        reset,
   // input elements
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_value,
   input  logic        req_is_final,
   // results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_out_value,
   output logic        rsp_out_final,
   // group size register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_group_size
);

   logic [brkg_pkg::CFG_W-1:0]   group_size_ff;
   logic [brkg_pkg::CFG_W-1:0]   group_size_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [brkg_pkg::VALUE_W-1:0] rsp_value_ff;
   logic                         rsp_final_ff;

   logic                         out_free;
   logic [brkg_pkg::VALUE_W-1:0] rd_data;
   brkg_pkg::brkg_wr_type        wr;
   brkg_pkg::brkg_rd_type        rd;
   brkg_pkg::brkg_rsp_ctl_type   rsp_ctl;

   // configuration register, reset to a group size of one
   assign csr_ready     = 1'b1;
   assign group_size_in = (csr_valid && csr_ready) ? csr_group_size : group_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         group_size_ff <= brkg_pkg::CFG_W'(1);
      end else begin
         group_size_ff <= group_size_in;
      end
   end

   // sequencer: tracks the fill level and walks the buffer for a drain
   brkg_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_value    (req_value),
      .req_is_final (req_is_final),
      .req_stall    (req_stall),
      .group_size   (group_size_ff),
      .out_free     (out_free),
      .wr           (wr),
      .rd           (rd),
      .rsp_ctl      (rsp_ctl)
   );

   // element store
   brkg_buffer u_buffer (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   // output stage: empty, or its transfer completes this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (rsp_ctl.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload follows the read data whenever a pending read is taken over
   always_ff @(posedge clock) begin
      if (rsp_ctl.load) begin
         rsp_value_ff <= rd_data;
         rsp_final_ff <= rsp_ctl.final_flag;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_out_final = rsp_final_ff;

endmodule
